FILE: sv/hr_pkg.sv
// Shared types and constants for the nearest-root Heron refinement block.
`timescale 1ns / 1ps
package hr_pkg;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROOT = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // bits retired per square-root digit step
    localparam int unsigned ROOT_DIGIT_BITS = 2;

endpackage

FILE: sv/hr_if.sv
// Valid/ready channel interfaces for radicand requests and root results.
`timescale 1ns / 1ps
interface hr_in_if #(
    parameter int unsigned W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

interface hr_out_if #(
    parameter int unsigned W = 33
);
    logic         valid;
    logic         ready;
    logic [W-1:0] root_estimate;

    modport source (output valid, output root_estimate, input ready);
    modport sink   (input valid, input root_estimate, output ready);
endinterface

FILE: sv/nearest_root_heron_refine.sv
// Top level: nearest integer square root refined by one Heron step.
//
// Usage
//   i_req carries one radicand per request (valid/ready); o_rsp returns one
//   root_estimate per request, unsigned fixed point with FRAC_BITS fraction
//   bits, truncated. A zero radicand returns zero.
// Timing
//   One request at a time. An accepted request runs the root digit steps,
//   the prep step and then the division steps before its result is valid
//   (RW = ceil(IN_WIDTH/2) root bits). A zero radicand goes straight to
//   done. Separate compare/subtract logic gives one root digit per cycle,
//   then one quotient bit per cycle shifted through the chain of bit cells.
// Reset
//   i_rst_n (synchronous, active low) returns the sequencer to idle and
//   drops o_rsp.valid. No stores to clear.
// Back-pressure
//   The result sits in an output register; the next request is accepted
//   while it waits. A finished result that cannot be handed over holds the
//   sequencer until o_rsp.ready frees the register.
`timescale 1ns / 1ps
module nearest_root_heron_refine #(
    parameter int unsigned IN_WIDTH  = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input logic     i_clk,
    input logic     i_rst_n,
    hr_in_if.sink   i_req,
    hr_out_if.source o_rsp
);
    import hr_pkg::*;

    localparam int unsigned RW = (IN_WIDTH + 1) / 2;            // root width
    localparam int unsigned SW = ROOT_DIGIT_BITS * RW;          // padded radicand
    localparam int unsigned OW = RW + 1 + FRAC_BITS;            // result width
    localparam int unsigned NW = IN_WIDTH + 2;                  // n + u^2
    localparam int unsigned DW = NW + FRAC_BITS;                // scaled dividend
    localparam int unsigned CW = $clog2(OW + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt;
    logic [IN_WIDTH-1:0] r_n;
    logic [SW-1:0]     r_sh;
    logic [RW:0]       r_rem;      // root remainder, at most 2r
    logic [RW-1:0]     r_root;
    logic [RW+1:0]     r_d;        // divisor 2u
    logic [RW+1:0]     r_drem;     // division remainder
    logic              r_zero;
    logic              r_ovalid;
    logic [OW-1:0]     r_odata;

    // root digit step
    logic [RW+2:0] w_rtrial, w_rrem2;
    logic          w_rge;
    // nearest root and Heron numerator
    logic          w_up;
    logic [RW:0]   w_u;
    logic [NW-1:0] w_num;
    logic [DW-1:0] w_dvd;
    // division step
    logic [OW-1:0] w_q;
    logic [RW+2:0] w_drem2;
    logic          w_dge;
    logic          w_load, w_shift, w_emit;

    assign w_rrem2  = {r_rem, r_sh[SW-1 -: ROOT_DIGIT_BITS]};
    assign w_rtrial = (RW + 3)'({r_root, 2'b01});
    assign w_rge    = w_rrem2 >= w_rtrial;

    // u = r unless (r+1)^2 - n <= n - r^2; with below = n - r^2 that is
    // 2r + 1 <= 2*below. u^2 comes from n - below (+ 2r + 1), no multiplier.
    assign w_up  = !((RW + 2)'({r_root, 1'b1}) > (RW + 2)'({r_rem, 1'b0}));
    assign w_u   = (RW + 1)'(r_root) + (RW + 1)'(w_up);
    assign w_num = (NW)'({r_n, 1'b0}) - (NW)'(r_rem)
                 + (w_up ? (NW)'({r_root, 1'b1}) : (NW)'(0));
    assign w_dvd = (DW)'(w_num) << FRAC_BITS;

    assign w_drem2 = {r_drem, w_q[OW-1]};
    assign w_dge   = w_drem2 >= (RW + 3)'(r_d);

    assign w_load  = (r_state == S_PREP);
    assign w_shift = (r_state == S_DIV);
    assign w_emit  = (r_state == S_DONE) && (!r_ovalid || o_rsp.ready);

    // chain of bit cells: holds the low dividend bits, collects quotient bits
    for (genvar g = 0; g < OW; g++) begin : g_cell
        hr_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_load),
            .i_load_bit  (w_dvd[g]),
            .i_shift     (w_shift),
            .i_shift_bit ((g == 0) ? w_dge : w_q[(g == 0) ? 0 : g - 1]),
            .o_bit       (w_q[g])
        );
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) begin
                n_state = (i_req.radicand == '0) ? S_DONE : S_ROOT;
            end
            S_ROOT: if (r_cnt == CW'(1)) begin
                n_state = S_PREP;
            end
            S_PREP: n_state = S_DIV;
            S_DIV:  if (r_cnt == CW'(1)) begin
                n_state = S_DONE;
            end
            S_DONE: if (w_emit) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_IDLE) begin
                r_cnt <= CW'(RW);
            end else if (r_state == S_PREP) begin
                r_cnt <= CW'(OW);
            end else if (r_state == S_ROOT || r_state == S_DIV) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_n    <= i_req.radicand;
            r_sh   <= (SW)'(i_req.radicand);
            r_rem  <= '0;
            r_root <= '0;
            r_zero <= (i_req.radicand == '0);
        end
        if (r_state == S_ROOT) begin
            r_sh   <= r_sh << ROOT_DIGIT_BITS;
            r_rem  <= w_rge ? (RW + 1)'(w_rrem2 - w_rtrial) : (RW + 1)'(w_rrem2);
            r_root <= {r_root[RW-2:0], w_rge};
        end
        if (r_state == S_PREP) begin
            r_d    <= {w_u, 1'b0};
            r_drem <= (RW + 2)'(w_dvd >> OW);
        end
        if (r_state == S_DIV) begin
            r_drem <= w_dge ? (RW + 2)'(w_drem2 - (RW + 3)'(r_d))
                            : (RW + 2)'(w_drem2);
        end
        if (w_emit) begin
            r_odata <= r_zero ? '0 : w_q;
        end
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.root_estimate = r_odata;
endmodule

FILE: sv/hr_cell.sv
// One bit cell of the dividend/quotient shift chain.
`timescale 1ns / 1ps
module hr_cell (
    input  logic i_clk,
    input  logic i_load,
    input  logic i_load_bit,
    input  logic i_shift,
    input  logic i_shift_bit,
    output logic o_bit
);
    import hr_pkg::*;

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_load) begin
            n_bit = i_load_bit;
        end else if (i_shift) begin
            n_bit = i_shift_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;
endmodule

FILE: sv/hr_checker.sv
// Port-level checker for the nearest-root Heron block, with its bind.
`timescale 1ns / 1ps
module hr_checker #(
    parameter int unsigned OW = 33
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [OW-1:0] i_out_data
);
    import hr_pkg::*;

    logic [1:0] r_pend;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // requests accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(w_in_acc) - 2'(w_out_acc);
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result without a request");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many requests in flight");
endmodule

bind nearest_root_heron_refine hr_checker #(
    .OW ((IN_WIDTH + 1) / 2 + 1 + FRAC_BITS)
) u_hr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.root_estimate)
);

FILE: bench/tb_nearest_root_heron_refine.sv
// Testbench for nearest_root_heron_refine: predicted roots checked against each response.
`timescale 1ns / 1ps
module tb_nearest_root_heron_refine;
    import hr_pkg::*;

    localparam int unsigned IN_W   = 32;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned OUT_W  = (IN_W + 1) / 2 + 1 + FRAC_W;
    localparam int unsigned LAT    = (IN_W + 1) / 2 + OUT_W + 3;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hr_in_if  #(.W(IN_W))  req_if ();
    hr_out_if #(.W(OUT_W)) rsp_if ();

    nearest_root_heron_refine #(.IN_WIDTH(IN_W), .FRAC_BITS(FRAC_W)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always #4 i_clk = ~i_clk;

    logic [IN_W-1:0]  radicands_pending[$];
    logic [OUT_W-1:0] roots_expected[$];
    int unsigned errors = 0;
    // idle rates in percent; hold_cycles is the long receiver stall
    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 77;
    int unsigned hold_cycles = 0;
    // request taken at the last rising edge
    bit in_acc = 1'b0;
    longint unsigned cycles = 0;

    // Nearest-root Heron estimate: floor((n + u^2) * 2^FRAC / (2u)), zero for n = 0.
    function automatic logic [OUT_W-1:0] heron_root(input logic [IN_W-1:0] n);
        logic [IN_W-1:0] r;
        logic [IN_W:0]   rem;
        logic [IN_W:0]   u;
        logic [127:0]    num;
        logic [127:0]    q;
        if (n == 0)
            return '0;
        // floor root by bitwise search
        r = '0;
        for (int b = IN_W / 2; b >= 0; b--) begin
            logic [IN_W-1:0] t;
            t = r | (IN_W'(1) << b);
            if (128'(t) * 128'(t) <= 128'(n))
                r = t;
        end
        rem = (IN_W + 1)'(n) - (IN_W + 1)'(r * r);
        // tie (above == below) goes to r+1
        u = ((2 * (IN_W + 1)'(r) + 1 - rem) > rem) ? (IN_W + 1)'(r) : (IN_W + 1)'(r) + 1;
        num = (128'(u) * 128'(u) + 128'(n)) << FRAC_W;
        q = num / (128'(u) * 2);
        return q[OUT_W-1:0];
    endfunction

    // Driver: presents requests from the pending queue at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid    <= 1'b0;
            req_if.radicand <= '0;
        end else if (!req_if.valid || in_acc) begin
            if (radicands_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_if.valid    <= 1'b1;
                req_if.radicand <= radicands_pending.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver readiness, with a long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles  <= hold_cycles - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: records accepted requests and compares each handed-over
    // result with the oldest prediction.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        in_acc <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready)
            roots_expected.push_back(heron_root(req_if.radicand));
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (roots_expected.size() == 0) begin
                $error("root_estimate: no request outstanding, got %0h", rsp_if.root_estimate);
                errors++;
            end else begin
                logic [OUT_W-1:0] exp_root;
                exp_root = roots_expected.pop_front();
                if (rsp_if.root_estimate !== exp_root) begin
                    $error("root_estimate: expected %0h, actual %0h",
                           exp_root, rsp_if.root_estimate);
                    errors++;
                end
            end
        end
    end

    function automatic logic [IN_W-1:0] random_radicand();
        logic [IN_W-1:0] s;
        int unsigned k;
        k = $urandom_range(5);
        case (k)
            0: begin
                return IN_W'($urandom_range(300));
            end
            1: begin
                // near a perfect square or a midpoint
                s = IN_W'($urandom_range(65535));
                return s * s + IN_W'($urandom_range(2 * s + 1)) - IN_W'($urandom_range(1));
            end
            2: begin
                return ~IN_W'($urandom_range(1000));
            end
            default: begin
                return IN_W'($urandom());
            end
        endcase
    endfunction

    task automatic drain();
        wait (radicands_pending.size() == 0 && !req_if.valid && roots_expected.size() == 0);
    endtask

    initial begin
        logic [IN_W-1:0] s;
        req_if.valid = 1'b0;
        req_if.radicand = '0;
        rsp_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, small values, exact squares, near-midpoints, every third bit alone
        radicands_pending.push_back('0);
        radicands_pending.push_back(IN_W'(1));
        radicands_pending.push_back(IN_W'(2));
        radicands_pending.push_back(IN_W'(3));
        radicands_pending.push_back(IN_W'(6));   // 6 = 2*3, between 2^2 and 3^2, nearest root 2
        radicands_pending.push_back(IN_W'(12));
        radicands_pending.push_back('1);
        radicands_pending.push_back(32'hFFFE_0001);
        radicands_pending.push_back(32'hFFFF_0000);  // just below the midpoint at the top
        radicands_pending.push_back(32'hAAAA_AAAA);
        radicands_pending.push_back(32'h5555_5555);
        for (int i = 0; i < IN_W; i += 3)
            radicands_pending.push_back(IN_W'(1) << i);

        // phase one: sender rarely idles, receiver mostly stalls
        for (int i = 0; i < 300; i++)
            radicands_pending.push_back(random_radicand());
        drain();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        for (int i = 0; i < 20; i++)
            radicands_pending.push_back(random_radicand());
        @(negedge i_clk);
        hold_cycles = 600;
        drain();

        send_idle_pct = 77;
        recv_idle_pct = 8;
        for (int i = 0; i < 300; i++)
            radicands_pending.push_back(random_radicand());
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 300; i++) begin
            s = random_radicand();
            radicands_pending.push_back(s);
        end
        drain();

        repeat (LAT + 10) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
